FILE: rtl/mtg_pkg.sv
// shared types and constants of the mt19937 random generator
`default_nettype none
package mtg_pkg;

	localparam int WORD_W      = 32;
	localparam int STATE_WORDS = 624;
	localparam int ADDR_W      = $clog2(STATE_WORDS + 2);
	localparam int TWIST_SHIFT = 397;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// index codes
	localparam addr_t FIRST_INDEX = addr_t'(0);
	localparam addr_t LAST_INDEX  = addr_t'(STATE_WORDS - 1);
	localparam addr_t UNSEEDED    = addr_t'(STATE_WORDS + 1);
	localparam addr_t FAR_OFFSET  = addr_t'(TWIST_SHIFT);
	localparam addr_t FAR_WRAP    = addr_t'(STATE_WORDS - TWIST_SHIFT);

	localparam word_t TWIST_MATRIX = 32'h9908b0df;
	localparam word_t TEMPER_B     = 32'h9d2c5680;
	localparam word_t TEMPER_C     = 32'hefc60000;
	localparam word_t SEED_MULT    = 32'd69069;
	localparam word_t SEED_DEFAULT = 32'd4357;

endpackage
`default_nettype wire

FILE: rtl/mtg_ram.sv
// generic simple ram: one write port, two registered read ports
`default_nettype none
module mtg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
`default_nettype wire

FILE: rtl/mtg_twist.sv
// twist of one state word and tempering of the result
`default_nettype none
module mtg_twist (
	input  wire mtg_pkg::word_t cur_word,
	input  wire mtg_pkg::word_t next_word,
	input  wire mtg_pkg::word_t far_word,
	output mtg_pkg::word_t      new_word,
	output mtg_pkg::word_t      tempered_word
);

	mtg_pkg::word_t y;
	mtg_pkg::word_t t1;
	mtg_pkg::word_t t2;
	mtg_pkg::word_t t3;

	always_comb begin
		y        = {cur_word[31], next_word[30:0]};
		new_word = far_word ^ (y >> 1) ^ (y[0] ? mtg_pkg::TWIST_MATRIX : '0);
		t1       = new_word ^ (new_word >> 11);
		t2       = t1 ^ ((t1 << 7) & mtg_pkg::TEMPER_B);
		t3       = t2 ^ ((t2 << 15) & mtg_pkg::TEMPER_C);
		tempered_word = t3 ^ (t3 >> 18);
	end

endmodule
`default_nettype wire

FILE: rtl/mt19937_random_generator_unit.sv
// mt19937 random generator: top level with control, state ram and output register
//
// input channel in_valid/in_ready carries draw; a transaction with draw high asks for
// one tempered 32-bit word, a transaction with draw low is taken and dropped
// output channel out_valid/out_ready carries random_word, held in an output register
// cfg_we/cfg_wdata writes the seed at once; it is used only by the seeding sweep
// the 624-word state sits in a ram with one write and two read ports; each draw
// twists the word at the read index in place (reads next and far words, writes back)
// a draw is taken only while idle, so the next one waits for the ram read and write-back of the last
// the result is loaded into the output register when the twist step (ST_COMP) fires
// the first draw after reset first runs a seeding sweep over all 624 words (one word per
// cycle through the 69069 multiplier), then the read step and the twist step
// reset clears control, restores the seed to 4357 and marks the state as unseeded
// a new draw is taken while a result waits; the twist step stalls while the output
// register is still full and out_ready is low
`default_nettype none
module mt19937_random_generator_unit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire mtg_pkg::word_t  cfg_wdata,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            draw,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output mtg_pkg::word_t       random_word
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SEED = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_COMP = 2'd3;

	logic [1:0]     state_q;
	mtg_pkg::addr_t idx_q;
	mtg_pkg::addr_t sc_q;
	mtg_pkg::word_t seed_q;
	mtg_pkg::word_t sv_q;
	mtg_pkg::word_t cur_q;
	logic           out_valid_q;
	mtg_pkg::word_t random_word_q;

	mtg_pkg::addr_t nxt_addr;
	mtg_pkg::addr_t far_addr;
	mtg_pkg::word_t rd_nxt;
	mtg_pkg::word_t rd_far;
	mtg_pkg::word_t new_word;
	mtg_pkg::word_t tempered_word;
	mtg_pkg::word_t seed_next;
	logic           mem_we;
	mtg_pkg::addr_t mem_waddr;
	mtg_pkg::word_t mem_wdata;
	logic           in_take;
	logic           comp_fire;

	assign in_ready    = (state_q == ST_IDLE);
	assign in_take     = in_valid && in_ready;
	assign comp_fire   = (state_q == ST_COMP) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;
	assign random_word = random_word_q;
	assign seed_next   = sv_q * mtg_pkg::SEED_MULT;

	// neighbor addresses of the word at the read index
	always_comb begin
		nxt_addr = (idx_q == mtg_pkg::LAST_INDEX) ? mtg_pkg::FIRST_INDEX
			: idx_q + mtg_pkg::addr_t'(1);
		far_addr = (idx_q >= mtg_pkg::FAR_WRAP) ? idx_q - mtg_pkg::FAR_WRAP
			: idx_q + mtg_pkg::FAR_OFFSET;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = new_word;
		if (state_q == ST_SEED) begin
			mem_we    = 1'b1;
			mem_waddr = sc_q;
			mem_wdata = sv_q;
		end else if (comp_fire) begin
			mem_we = 1'b1;
		end
	end

	mtg_ram #(
		.WIDTH(mtg_pkg::WORD_W),
		.DEPTH(mtg_pkg::STATE_WORDS)
	) u_state_ram (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr_a(nxt_addr),
		.rdata_a(rd_nxt),
		.raddr_b(far_addr),
		.rdata_b(rd_far)
	);

	mtg_twist u_twist (
		.cur_word     (cur_q),
		.next_word    (rd_nxt),
		.far_word     (rd_far),
		.new_word     (new_word),
		.tempered_word(tempered_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= mtg_pkg::UNSEEDED;
			sc_q        <= mtg_pkg::FIRST_INDEX;
			seed_q      <= mtg_pkg::SEED_DEFAULT;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take && draw) begin
						if (idx_q == mtg_pkg::UNSEEDED) begin
							state_q <= ST_SEED;
							sc_q    <= mtg_pkg::FIRST_INDEX;
						end else begin
							state_q <= ST_COMP;
						end
					end
				end
				ST_SEED: begin
					sc_q <= sc_q + mtg_pkg::addr_t'(1);
					if (sc_q == mtg_pkg::LAST_INDEX) begin
						idx_q   <= mtg_pkg::FIRST_INDEX;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_COMP;
				end
				ST_COMP: begin
					if (comp_fire) begin
						out_valid_q <= 1'b1;
						idx_q       <= nxt_addr;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_take && draw && idx_q == mtg_pkg::UNSEEDED) begin
			sv_q <= seed_q;
		end else if (state_q == ST_SEED) begin
			sv_q <= seed_next;
		end
		// cur_q tracks the word at the read index
		if (state_q == ST_SEED && sc_q == mtg_pkg::FIRST_INDEX) begin
			cur_q <= sv_q;
		end else if (comp_fire) begin
			cur_q <= rd_nxt;
		end
		if (comp_fire) begin
			random_word_q <= tempered_word;
		end
	end

`ifndef SYNTH
	a_comp_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP) |-> (idx_q <= mtg_pkg::LAST_INDEX))
		else $error("twist step with read index out of range");

	a_seed_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && draw && idx_q == mtg_pkg::UNSEEDED) |=> (state_q == ST_SEED))
		else $error("first draw did not start the seeding sweep");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mem_we)
		else $error("state ram written while idle");

	a_read_after_seed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (idx_q == mtg_pkg::FIRST_INDEX && $past(state_q) == ST_SEED))
		else $error("read step not entered from the end of seeding");

	a_result_fill: assert property (@(posedge clk) disable iff (!arst_n)
		comp_fire |=> (out_valid_q && state_q == ST_IDLE))
		else $error("twist step did not load the output register");
`endif

endmodule
`default_nettype wire

FILE: dv/tb_mt19937_random_generator_unit.sv
`timescale 1ns / 1ps
// testbench for the mt19937 random generator unit, checking every drawn word against a predictor
module tb_mt19937_random_generator_unit;

	localparam int N_WORDS       = 624;
	localparam int MID_OFFSET    = 397;
	localparam int NOT_SEEDED    = N_WORDS + 1;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS   = 10;

	localparam mtg_pkg::word_t TWIST_POLY = 32'h9908b0df;
	localparam mtg_pkg::word_t UPPER_BIT  = 32'h80000000;
	localparam mtg_pkg::word_t LOWER_BIT  = 32'h7fffffff;
	localparam mtg_pkg::word_t MASK_B     = 32'h9d2c5680;
	localparam mtg_pkg::word_t MASK_C     = 32'hefc60000;
	localparam mtg_pkg::word_t LCG_MULT   = 32'd69069;
	localparam mtg_pkg::word_t SEED_RST   = 32'd4357;
	localparam mtg_pkg::word_t ALL_ONES   = 32'hffffffff;

	typedef struct packed {
		logic       d;
		logic [3:0] gap;
	} draw_row_t;

	localparam int N_ROWS = 20;
	// first row triggers the seeding sweep; draw-low rows mixed in at various spacings
	localparam draw_row_t DIRECTED [0:N_ROWS-1] = '{
		'{1'b1, 4'd0}, '{1'b0, 4'd0}, '{1'b1, 4'd0}, '{1'b1, 4'd0}, '{1'b0, 4'd3},
		'{1'b0, 4'd0}, '{1'b1, 4'd0}, '{1'b1, 4'd1}, '{1'b1, 4'd0}, '{1'b0, 4'd15},
		'{1'b1, 4'd0}, '{1'b1, 4'd2}, '{1'b0, 4'd0}, '{1'b1, 4'd0}, '{1'b1, 4'd0},
		'{1'b1, 4'd0}, '{1'b0, 4'd1}, '{1'b1, 4'd0}, '{1'b1, 4'd7}, '{1'b1, 4'd0}
	};

	logic           clk;
	logic           arst_n;
	logic           cfg_we;
	mtg_pkg::word_t cfg_wdata;
	logic           in_valid;
	logic           in_ready;
	logic           draw;
	logic           out_valid;
	logic           out_ready = 1'b0;
	mtg_pkg::word_t random_word;

	// generator shadow state
	mtg_pkg::word_t mt_state [N_WORDS];
	int             mt_idx = NOT_SEEDED;
	mtg_pkg::word_t seed_shadow = SEED_RST;
	mtg_pkg::word_t expected_words [$];
	int             err_count = 0;

	mt19937_random_generator_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.draw       (draw),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.random_word(random_word)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic seed_state();
		int k;
		mt_state[0] = seed_shadow;
		for (k = 1; k < N_WORDS; k++) begin
			mt_state[k] = mt_state[k-1] * LCG_MULT;
		end
	endtask

	task automatic twist_state();
		int             k;
		int             nxt;
		int             far;
		mtg_pkg::word_t y;
		mtg_pkg::word_t v;
		for (k = 0; k < N_WORDS; k++) begin
			nxt = (k + 1 < N_WORDS) ? k + 1 : 0;
			far = k + MID_OFFSET;
			if (far >= N_WORDS) begin
				far -= N_WORDS;
			end
			y = (mt_state[k] & UPPER_BIT) | (mt_state[nxt] & LOWER_BIT);
			v = mt_state[far] ^ (y >> 1);
			if (y[0]) begin
				v ^= TWIST_POLY;
			end
			mt_state[k] = v;
		end
	endtask

	function automatic mtg_pkg::word_t temper_word(input mtg_pkg::word_t w);
		mtg_pkg::word_t y;
		y = w;
		y ^= y >> 11;
		y ^= (y << 7) & MASK_B;
		y ^= (y << 15) & MASK_C;
		y ^= y >> 18;
		return y;
	endfunction

	task automatic next_tempered_word(output mtg_pkg::word_t w);
		if (mt_idx >= N_WORDS) begin
			if (mt_idx == NOT_SEEDED) begin
				seed_state();
			end
			twist_state();
			mt_idx = 0;
		end
		w = temper_word(mt_state[mt_idx]);
		mt_idx = (mt_idx + 1) & 10'h3ff;
	endtask

	// sample at the rising edge: seed writes, result transactions, draw transactions
	always @(posedge clk) begin
		mtg_pkg::word_t want;
		if (arst_n) begin
			if (cfg_we) begin
				seed_shadow = cfg_wdata;
			end
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					err_count++;
					if (err_count <= MAX_REPORTS) begin
						$display("unexpected word %h at %0t", random_word, $realtime);
					end
				end else begin
					want = expected_words.pop_front();
					if (random_word !== want) begin
						err_count++;
						if (err_count <= MAX_REPORTS) begin
							$display("random_word mismatch: expected %h, got %h at %0t",
								want, random_word, $realtime);
						end
					end
				end
			end
			if (in_valid && in_ready && draw) begin
				next_tempered_word(want);
				expected_words.push_back(want);
			end
		end
	end

	// receiver: takes turns between always ready, random stalls and long stalls
	int rx_cyc = 0;
	int stall_left = 0;
	always @(negedge clk) begin
		rx_cyc++;
		case ((rx_cyc / 150) % 3)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				if (stall_left > 0) begin
					stall_left--;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
					if ($urandom_range(0, 4) == 0) begin
						stall_left = $urandom_range(1, 8);
					end
				end
			end
		endcase
	end

	task automatic send_draw(input logic d, input int gap);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
			draw     <= 1'($urandom);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		draw     <= d;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop sending and wait until every word has come back
	task automatic settle_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_seed(input mtg_pkg::word_t v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// n_draws counts every transaction sent, draw high or low
	task automatic run_random_draws(input int n_draws);
		int   sent;
		int   burst_left;
		int   gap;
		logic d;
		sent       = 0;
		burst_left = 0;
		while (sent < n_draws) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
			end else begin
				gap = 0;
			end
			burst_left--;
			d = ($urandom_range(0, 9) != 0);
			send_draw(d, gap);
			sent++;
		end
	endtask

	initial begin
		mtg_pkg::word_t live_seed;
		int             r;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		draw      = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// only the last seed before the first draw counts
		live_seed = ($urandom_range(0, 3) == 0) ? SEED_RST : mtg_pkg::word_t'($urandom);
		write_seed('0);
		write_seed(ALL_ONES);
		write_seed(live_seed);

		for (r = 0; r < N_ROWS; r++) begin
			send_draw(DIRECTED[r].d, int'(DIRECTED[r].gap));
		end

		// seed writes after the first draw must leave the sequence alone
		settle_idle();
		write_seed('0);
		run_random_draws(450);

		settle_idle();
		write_seed(ALL_ONES);
		write_seed(mtg_pkg::word_t'($urandom));
		run_random_draws(480);

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0 && expected_words.size() == 0) begin
			$display("mt19937_random_generator_unit test passed");
		end else begin
			$display("mt19937_random_generator_unit test failed");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("mt19937_random_generator_unit test failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/mtg_pkg.sv
rtl/mtg_ram.sv
rtl/mtg_twist.sv
rtl/mt19937_random_generator_unit.sv
dv/tb_mt19937_random_generator_unit.sv
